@@ rtl/core/amdfs_pkg.sv @@
// Shared types, constants and helper functions of the adjacency-matrix
// depth-first order block. Depends on nothing; imported by all modules but amdfs_ram.
package amdfs_pkg;

    localparam int VTX_W   = 5;   // width of a vertex number
    localparam int ROW_W   = 32;  // width of one adjacency row
    localparam int DEPTH_W = 6;   // width of the stack depth and the vertex count
    localparam int ROWS    = 32;  // entries in the adjacency and stack memories

    localparam logic [DEPTH_W-1:0] MAX_VERTICES  = 6'd32;
    localparam logic [DEPTH_W-1:0] COUNT_AT_RESET = 6'd32;

    localparam logic FUNC_ROW_WRITE = 1'b0;
    localparam logic FUNC_RUN       = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             last;
        logic             status;
    } result_t;

    typedef struct packed {
        logic             we;
        logic [VTX_W-1:0] waddr;
        logic [ROW_W-1:0] wdata;
        logic [VTX_W-1:0] raddr;
    } adj_req_t;

    typedef struct packed {
        logic             we;
        logic [VTX_W-1:0] waddr;
        logic [VTX_W-1:0] wdata;
        logic [VTX_W-1:0] raddr;
    } stk_req_t;

    typedef struct packed {
        logic               busy;
        logic [DEPTH_W-1:0] depth;
    } ctrl_status_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [VTX_W-1:0] lowest_index(input logic [ROW_W-1:0] v);
        logic [VTX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = VTX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/amdfs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; holds the adjacency rows and the vertex stack.
module amdfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/amdfs_ctrl.sv @@
// Traversal sequencer: row loading, stack pops and pushes, visited marks.
// Depends on amdfs_pkg; drives the adjacency and stack memories in the top level.
module amdfs_ctrl
    import amdfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_func,
    input  logic [VTX_W-1:0]   in_row_index,
    input  logic [ROW_W-1:0]   in_row_bits,
    input  logic [VTX_W-1:0]   in_start,
    input  logic [DEPTH_W-1:0] vertex_count,
    output adj_req_t           adj_req,
    input  logic [ROW_W-1:0]   adj_rdata,
    output stk_req_t           stk_req,
    input  logic [VTX_W-1:0]   stk_rdata,
    output logic               emit_valid,
    output result_t            emit_item,
    input  logic               emit_ready,
    output ctrl_status_t       status
);

    state_t             state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [ROW_W-1:0]   visited_reg, visited_next;
    logic [ROW_W-1:0]   cand_reg, cand_next;
    logic [VTX_W-1:0]   k_reg, k_next;

    logic [DEPTH_W-1:0] active_n;
    logic [ROW_W-1:0]   active_mask;
    logic               start_ok;

    // Effective vertex count, capped at the memory size.
    assign active_n    = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
    assign active_mask = (active_n >= MAX_VERTICES) ? '1
                       : ((ROW_W'(1) << active_n) - ROW_W'(1));
    assign start_ok    = {1'b0, in_start} < active_n;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_func == FUNC_RUN)
                begin
                    state_next = start_ok ? ST_POP : ST_ERR;
                end
            end
            ST_POP:   state_next = ST_FETCH;
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (cand_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ready)
                begin
                    state_next = (depth_reg == '0) ? ST_IDLE : ST_POP;
                end
            end
            ST_ERR:
            begin
                if (emit_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        depth_next   = depth_reg;
        visited_next = visited_reg;
        cand_next    = cand_reg;
        k_next       = k_reg;
        adj_req      = '0;
        stk_req      = '0;
        emit_valid   = 1'b0;
        emit_item    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_func == FUNC_ROW_WRITE)
                begin
                    adj_req.we    = 1'b1;
                    adj_req.waddr = in_row_index;
                    adj_req.wdata = in_row_bits;
                end
                else if (in_valid)
                begin
                    visited_next = '0;
                    depth_next   = '0;
                    if (start_ok)
                    begin
                        stk_req.we    = 1'b1;
                        stk_req.waddr = '0;
                        stk_req.wdata = in_start;
                        depth_next    = DEPTH_W'(1);
                        visited_next  = ROW_W'(1) << in_start;
                    end
                end
            end
            ST_POP:
            begin
                depth_next    = depth_reg - DEPTH_W'(1);
                stk_req.raddr = depth_next[VTX_W-1:0];
            end
            ST_FETCH:
            begin
                k_next        = stk_rdata;
                adj_req.raddr = stk_rdata;
            end
            ST_LOAD:
            begin
                cand_next = adj_rdata & ~visited_reg & active_mask;
            end
            ST_SCAN:
            begin
                if (cand_reg != '0)
                begin
                    // Push the lowest unvisited neighbour and mark it at once.
                    stk_req.we    = 1'b1;
                    stk_req.waddr = depth_reg[VTX_W-1:0];
                    stk_req.wdata = lowest_index(cand_reg);
                    depth_next    = depth_reg + DEPTH_W'(1);
                    visited_next  = visited_reg | (cand_reg & (~cand_reg + ROW_W'(1)));
                    cand_next     = cand_reg & (cand_reg - ROW_W'(1));
                end
            end
            ST_EMIT:
            begin
                emit_valid       = 1'b1;
                emit_item.vertex = k_reg;
                emit_item.last   = (depth_reg == '0);
                emit_item.status = STATUS_OK;
            end
            ST_ERR:
            begin
                emit_valid       = 1'b1;
                emit_item.vertex = '0;
                emit_item.last   = 1'b1;
                emit_item.status = STATUS_RANGE;
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            visited_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            visited_reg <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        k_reg    <= k_next;
    end

    assign status.busy  = (state_reg != ST_IDLE);
    assign status.depth = depth_reg;

endmodule

@@ rtl/core/amdfs_out.sv @@
// Output register between the sequencer and the result stream.
// Depends on amdfs_pkg for the result type.
module amdfs_out
    import amdfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    emit_valid,
    input  result_t emit_item,
    output logic    emit_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    logic    valid_reg, valid_next;
    result_t item_reg;

    // The register takes a new word when empty or when its word leaves now.
    assign emit_ready = !valid_reg || out_ready;
    assign valid_next = emit_ready ? emit_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ready && emit_valid)
        begin
            item_reg <= emit_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/core/adjacency_matrix_dfs_order_core.sv @@
// Top level of the depth-first visit order block over an adjacency matrix.
// Depends on amdfs_pkg, amdfs_ram, amdfs_ctrl and amdfs_out.
//
// Usage. Input words arrive on the s_axis channel. With tuser low a word
// writes one adjacency row (row_index, row_bits) and gives no result. With
// tuser high a word starts a traversal from start_vertex: the visited marks
// are cleared and every vertex reachable from the start is sent once on the
// m_axis channel in depth-first order, tlast marking the final word. A start
// vertex at or above the vertex count gives one word with vertex 0, tlast
// high and tuser (status) high.
// Sequence. For each vertex sent a traversal steps through the states pop,
// fetch, load, scan and emit, and in scan it pushes one neighbour at a time
// through the single write port of the stack memory. The first word reaches
// m_axis through the output register once the start vertex has been through
// these states. An out-of-range start sends its error word from the error state.
// A new input word is taken once the sequencer is idle, even while the last
// result still waits in the output register.
// Reset clears the sequencer, the visited marks and the stack depth, and sets
// the vertex count to 32; the row memory holds nothing valid until written.
// When the receiver stalls, the output register holds its word and the
// sequencer waits before sending the next one, so nothing is lost.
// The user writes the vertex count through cfg_we and cfg_wdata only while idle; the block does not enforce this.
module adjacency_matrix_dfs_order_core
    import amdfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [4:0] row_index, [36:5] row_bits, [41:37] start_vertex, [47:42] zero
    input  logic [47:0]        s_axis_tdata,
    // [0] func
    input  logic               s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [4:0] visited_vertex, [7:5] zero
    output logic [7:0]         m_axis_tdata,
    // last
    output logic               m_axis_tlast,
    // [0] status
    output logic               m_axis_tuser,
    input  logic               cfg_we,
    input  logic [DEPTH_W-1:0] cfg_wdata
);

    logic [DEPTH_W-1:0] count_reg, count_next;
    adj_req_t           adj_req;
    stk_req_t           stk_req;
    logic [ROW_W-1:0]   adj_rdata;
    logic [VTX_W-1:0]   stk_rdata;
    logic               emit_valid;
    logic               emit_ready;
    result_t            emit_item;
    result_t            out_item;
    ctrl_status_t       ctrl_status;

    // Vertex count register.
    assign count_next = cfg_we ? cfg_wdata : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_AT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Adjacency rows, one per source vertex.
    amdfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_req.we),
        .waddr (adj_req.waddr),
        .wdata (adj_req.wdata),
        .raddr (adj_req.raddr),
        .rdata (adj_rdata)
    );

    // Vertex stack of the traversal.
    amdfs_ram #(
        .WIDTH (VTX_W),
        .DEPTH (ROWS)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_req.we),
        .waddr (stk_req.waddr),
        .wdata (stk_req.wdata),
        .raddr (stk_req.raddr),
        .rdata (stk_rdata)
    );

    amdfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_func      (s_axis_tuser),
        .in_row_index (s_axis_tdata[4:0]),
        .in_row_bits  (s_axis_tdata[36:5]),
        .in_start     (s_axis_tdata[41:37]),
        .vertex_count (count_reg),
        .adj_req      (adj_req),
        .adj_rdata    (adj_rdata),
        .stk_req      (stk_req),
        .stk_rdata    (stk_rdata),
        .emit_valid   (emit_valid),
        .emit_item    (emit_item),
        .emit_ready   (emit_ready),
        .status       (ctrl_status)
    );

    amdfs_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_valid (emit_valid),
        .emit_item  (emit_item),
        .emit_ready (emit_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    assign m_axis_tdata = {3'b000, out_item.vertex};
    assign m_axis_tlast = out_item.last;
    assign m_axis_tuser = out_item.status;

    // Every vertex is pushed at most once, so the stack never overflows.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_status.depth <= MAX_VERTICES)
    else $error("vertex stack depth beyond its capacity");

    // An out-of-range start is always the single, final word of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_RANGE |-> m_axis_tlast)
    else $error("range error word sent without tlast");

    // The sequencer only leaves idle on an accepted traversal request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctrl_status.busy) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_RUN))
    else $error("sequencer started without a traversal request");

endmodule

@@ tb/sv/adjacency_matrix_dfs_order_checker.sv @@
`timescale 1ns / 1ps
// Watches the word channels and the count register of the depth-first order block.
// It predicts each traversal and compares every result word. Depends on amdfs_pkg.
module adjacency_matrix_dfs_order_checker
    import amdfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [47:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata,
    input  logic               m_tlast,
    input  logic               m_tuser,
    input  logic               cfg_we,
    input  logic [DEPTH_W-1:0] cfg_wdata,
    output int                 mismatch_count,
    output int                 visits_due,
    output int                 visits_seen
);

    logic [ROW_W-1:0]   adj_rows [ROWS];
    logic [DEPTH_W-1:0] vertex_limit;
    result_t            visit_order_due [$];

    // Works out the words one traversal from root should produce.
    function automatic void predict_visit_order(input logic [VTX_W-1:0] root);
        logic [ROW_W-1:0] marks;
        logic [VTX_W-1:0] pile [ROWS];
        logic [VTX_W-1:0] popped;
        logic [ROW_W-1:0] nbrs;
        int               depth;
        int               span;
        result_t          word;
        span = (vertex_limit > MAX_VERTICES) ? ROWS : int'(vertex_limit);
        if (int'(root) >= span)
        begin
            word.vertex = '0;
            word.last   = 1'b1;
            word.status = STATUS_RANGE;
            visit_order_due.push_back(word);
            return;
        end
        marks       = '0;
        marks[root] = 1'b1;
        pile[0]     = root;
        depth       = 1;
        while (depth > 0)
        begin
            depth  = depth - 1;
            popped = pile[depth];
            nbrs   = adj_rows[popped];
            for (int i = 0; i < span; i++)
            begin
                if (nbrs[i] && !marks[i])
                begin
                    pile[depth] = VTX_W'(i);
                    depth       = depth + 1;
                    marks[i]    = 1'b1;
                end
            end
            word.vertex = popped;
            word.last   = (depth == 0);
            word.status = STATUS_OK;
            visit_order_due.push_back(word);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            visit_order_due.delete();
            vertex_limit   = COUNT_AT_RESET;
            mismatch_count = 0;
            visits_seen    = 0;
        end
        else
        begin
            // Results first, so a run taken on the same edge queues behind them.
            if (m_tvalid && m_tready)
            begin
                visits_seen = visits_seen + 1;
                if (visit_order_due.size() == 0)
                begin
                    $error("unexpected result word: vertex %0d last %0b status %0b",
                           m_tdata[VTX_W-1:0], m_tlast, m_tuser);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = visit_order_due.pop_front();
                    if (m_tdata[VTX_W-1:0] !== want.vertex)
                    begin
                        $error("visited_vertex: expected %0d, actual %0d",
                               want.vertex, m_tdata[VTX_W-1:0]);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0b, actual %0b", want.status, m_tuser);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == FUNC_ROW_WRITE)
                    adj_rows[s_tdata[4:0]] = s_tdata[36:5];
                else
                    predict_visit_order(s_tdata[41:37]);
            end
            if (cfg_we)
                vertex_limit = cfg_wdata;
        end
    end

    // Published away from the rising edge so the stimulus side reads it without a race.
    always @(negedge clk)
        visits_due = visit_order_due.size();

endmodule

@@ tb/sv/adjacency_matrix_dfs_order_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the regression for adjacency_matrix_dfs_order_core: clock, reset, stimulus and verdict.
// Depends on amdfs_pkg, the block itself and adjacency_matrix_dfs_order_checker.
module adjacency_matrix_dfs_order_core_tb;
    import amdfs_pkg::*;

    // The longest legal traversal is 32 words, each through the sequencer
    // states, plus a push per neighbour; even with the receiver stalling most
    // cycles a quiet spell this long would be unusual, so this is generous.
    localparam int WATCHDOG_LIMIT = 4000;
    // A row write is done while the sequencer is idle and gives no word back,
    // so this many cycles after the final result the block is surely idle.
    localparam int SETTLE_CYCLES  = 8;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata  = '0;
    logic               s_axis_tuser  = FUNC_ROW_WRITE;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;
    logic               cfg_we        = 1'b0;
    logic [DEPTH_W-1:0] cfg_wdata     = COUNT_AT_RESET;

    int                 mismatch_count;
    int                 visits_due;
    int                 visits_seen;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int                 gap_pct       = 0;
    int                 stall_pct     = 0;
    int                 quiet_cycles  = 0;
    int                 words_sent    = 0;
    int                 runs_sent     = 0;
    // The vertex count last written, so that most random starts land in range.
    int                 count_now     = 32;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    adjacency_matrix_dfs_order_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    adjacency_matrix_dfs_order_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tuser        (s_axis_tuser),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tlast        (m_axis_tlast),
        .m_tuser        (m_axis_tuser),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .visits_due     (visits_due),
        .visits_seen    (visits_seen)
    );

    // The receiver decides afresh every cycle whether to take a result word.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Any accepted word or register write counts as progress; a long spell
    // without any means the block has hung or lost a result.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("adjacency_matrix_dfs_order_core regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one input word and returns on the edge that accepts it. The
    // fields that the chosen function ignores still carry whatever the caller
    // gives, so their bits toggle as well. Valid is left high on return; the
    // next call or the drain decides what it does next.
    task automatic send_word(input logic fn, input logic [VTX_W-1:0] row_index,
                             input logic [ROW_W-1:0] row_bits,
                             input logic [VTX_W-1:0] start_vertex);
        if ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {6'b0, start_vertex, row_bits, row_index};
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent = words_sent + 1;
        if (fn == FUNC_RUN)
            runs_sent = runs_sent + 1;
    endtask

    task automatic run_from(input logic [VTX_W-1:0] start_vertex);
        send_word(FUNC_RUN, VTX_W'($urandom), $urandom, start_vertex);
    endtask

    task automatic write_row(input logic [VTX_W-1:0] row_index, input logic [ROW_W-1:0] bits);
        send_word(FUNC_ROW_WRITE, row_index, bits, VTX_W'($urandom));
    endtask

    // Stops offering words, waits for every predicted result to come back and
    // then lets the sequencer finish any row write still in hand.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (visits_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The count register is only touched once the block is idle.
    task automatic set_vertex_count(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= DEPTH_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_now = value;
    endtask

    // One random word. Row writes use a spread of densities so that some
    // graphs are nearly complete and others sparse, which gives long chains
    // of pushes and pops. Most runs start inside the vertex count; the rest
    // may land anywhere and so exercise the out-of-range answer.
    task automatic random_word;
        logic [VTX_W-1:0] idx;
        logic [ROW_W-1:0] bits;
        int               span;
        idx  = VTX_W'($urandom_range(ROWS - 1));
        span = (count_now > ROWS) ? ROWS : count_now;
        case ($urandom_range(5))
            0: bits = $urandom;
            1: bits = $urandom & $urandom;
            2: bits = $urandom & $urandom & $urandom;
            3: bits = 32'h1 << $urandom_range(ROWS - 1);
            4: bits = (32'h1 << VTX_W'(idx + 5'd1)) | ($urandom & $urandom & $urandom & $urandom);
            default: bits = '0;
        endcase
        if ($urandom_range(99) < 55)
            write_row(idx, bits);
        else if (span == 0 || $urandom_range(99) < 15)
            run_from(VTX_W'($urandom));
        else
            run_from(VTX_W'($urandom_range(span - 1)));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The row memory holds nothing valid after reset, so every row is
        // written before the first traversal: a ring in which each vertex
        // leads to the next one.
        for (int i = 0; i < ROWS; i++)
            write_row(VTX_W'(i), 32'h1 << ((i + 1) % ROWS));

        // Directed part. The first and last rows connect to everything, a
        // vertex with only a self loop and one with no edges at all stand
        // alone, and traversals start from both ends of the vertex range.
        write_row(5'd0, 32'hFFFF_FFFF);
        write_row(5'd31, 32'hFFFF_FFFF);
        write_row(5'd7, 32'h0000_0080);
        write_row(5'd3, 32'h0000_0000);
        run_from(5'd0);
        run_from(5'd31);
        run_from(5'd7);
        run_from(5'd3);
        run_from(5'd12);

        // A small count: neighbours above it are ignored and starts at or
        // above it give the error word.
        set_vertex_count(5);
        run_from(5'd4);
        run_from(5'd5);
        run_from(5'd31);
        // A count of zero puts every start out of range.
        set_vertex_count(0);
        run_from(5'd0);
        // A single vertex: the fully connected row yields just that vertex.
        set_vertex_count(1);
        run_from(5'd0);
        run_from(5'd1);
        // A count above the memory size is capped at 32.
        set_vertex_count(63);
        run_from(5'd0);
        run_from(5'd30);

        // Random part in four idling phases, each under its own count.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_vertex_count(32);
                1: set_vertex_count(9);
                2: set_vertex_count(63);
                default: set_vertex_count(2);
            endcase
            case (phase)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    gap_pct   = 24;
                    stall_pct = 24;
                end
            endcase
            repeat (55) random_word();
        end

        drain();
        $display("Sent %0d input words, %0d of them traversals, and checked %0d result words.",
                 words_sent, runs_sent, visits_seen);
        $display("Vertex counts 0, 1, 2, 5, 9, 32 and 63; idling none, sender, receiver, both.");
        if (mismatch_count == 0)
        begin
            $display("adjacency_matrix_dfs_order_core regression: pass");
        end
        else
        begin
            $display("adjacency_matrix_dfs_order_core regression: fail");
        end
        $finish;
    end

endmodule
